[rtl/dep_pkg.sv]
// ----------------------------------------------------------------------------
// dep_pkg: shared types and constants
// Field widths, item kinds and the queue entry that travels from the front
// end to the back end of the dictionary expander.
// ----------------------------------------------------------------------------
package dep_pkg;

  localparam int CODE_W  = 12;
  localparam int LEN_W   = 7;
  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int DOC_W   = 16;
  localparam int SUM_W   = 24;
  localparam int ENTRY_W = ADDR_W + LEN_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_LOAD_CODE = 2'd0,
    KIND_LOAD_DICT = 2'd1,
    KIND_START     = 2'd2,
    KIND_CODE      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    Q_DICT_WR = 2'd0,
    Q_START   = 2'd1,
    Q_EXPAND  = 2'd2,
    Q_ERROR   = 2'd3
  } q_op_t;

  // One unit of work for the back end. addr is the dictionary byte address
  // or the segment base, data is the byte to write or the document length.
  typedef struct packed {
    q_op_t              op;
    logic [ADDR_W-1:0]  addr;
    logic [DOC_W-1:0]   data;
    logic [LEN_W-1:0]   seg;
  } q_entry_t;

endpackage

[rtl/dep_if.sv]
// ----------------------------------------------------------------------------
// dep_if: stream channels of the dictionary expander
// Input item channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dep_in_if;
  import dep_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [CODE_W-1:0]   code;
  logic [LEN_W-1:0]    entry_length;
  logic [ADDR_W-1:0]   address;
  logic [BYTE_W-1:0]   dict_byte;
  logic [DOC_W-1:0]    doc_length;

  modport source (
    output valid, kind, code, entry_length, address, dict_byte, doc_length,
    input  ready
  );
  modport sink (
    input  valid, kind, code, entry_length, address, dict_byte, doc_length,
    output ready
  );
endinterface

interface dep_out_if;
  import dep_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  length_byte;
  logic [SUM_W-1:0]   running_offset;
  logic               last;
  logic               doc_done;
  logic               load_error;

  modport source (
    output valid, length_byte, running_offset, last, doc_done, load_error,
    input  ready
  );
  modport sink (
    input  valid, length_byte, running_offset, last, doc_done, load_error,
    output ready
  );
endinterface

[rtl/dep_front.sv]
// ----------------------------------------------------------------------------
// dep_front: item intake and code table
// Accepts input beats, writes code table entries, looks up codes and turns
// every item that needs further work into a queue entry.
// ----------------------------------------------------------------------------
module dep_front #(
  parameter int CODE_TABLE_DEPTH = 4096,
  parameter int MAX_SEGMENT      = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  dep_in_if.sink            in_ch,
  output dep_pkg::q_entry_t q_data,
  output logic              q_valid,
  input  logic              q_ready
);
  import dep_pkg::*;

  // The table depth is a power of two, so the code index wraps by truncation.
  localparam int CI_W = $clog2(CODE_TABLE_DEPTH);

  logic [ENTRY_W-1:0] tbl_mem [CODE_TABLE_DEPTH];
  logic [ENTRY_W-1:0] tbl_rd_r;

  logic               s1_valid_r, s1_valid_nxt;
  q_op_t              s1_op_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [DOC_W-1:0]   s1_data_r;

  logic               in_acc;
  logic               len_bad;
  logic               need_push;
  logic [CI_W-1:0]    cidx;
  kind_t              kind;

  assign kind      = kind_t'(in_ch.kind);
  assign cidx      = CI_W'(in_ch.code);
  assign len_bad   = in_ch.entry_length > LEN_W'(MAX_SEGMENT);
  assign in_ch.ready = !s1_valid_r || q_ready;
  assign in_acc    = in_ch.valid && in_ch.ready;

  // A good code entry load is finished once the table is written.
  assign need_push = !(kind == KIND_LOAD_CODE && !len_bad);

  always_ff @(posedge clk) begin
    if (in_acc && kind == KIND_LOAD_CODE && !len_bad) begin
      tbl_mem[cidx] <= {in_ch.address, in_ch.entry_length};
    end
    if (in_acc && kind == KIND_CODE) begin
      tbl_rd_r <= tbl_mem[cidx];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_valid_r && q_ready) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_valid_nxt = need_push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (kind)
        KIND_LOAD_CODE: begin
          s1_op_r   <= Q_ERROR;
          s1_addr_r <= in_ch.address;
          s1_data_r <= '0;
        end
        KIND_LOAD_DICT: begin
          s1_op_r   <= Q_DICT_WR;
          s1_addr_r <= in_ch.address;
          s1_data_r <= DOC_W'(in_ch.dict_byte);
        end
        KIND_START: begin
          s1_op_r   <= Q_START;
          s1_addr_r <= in_ch.address;
          s1_data_r <= in_ch.doc_length;
        end
        default: begin
          s1_op_r   <= Q_EXPAND;
          s1_addr_r <= in_ch.address;
          s1_data_r <= in_ch.doc_length;
        end
      endcase
    end
  end

  always_comb begin
    q_data.op   = s1_op_r;
    q_data.addr = s1_addr_r;
    q_data.data = s1_data_r;
    q_data.seg  = '0;
    if (s1_op_r == Q_EXPAND) begin
      q_data.addr = tbl_rd_r[ENTRY_W-1:LEN_W];
      q_data.seg  = tbl_rd_r[LEN_W-1:0];
    end
  end

  assign q_valid = s1_valid_r;

endmodule

[rtl/dep_queue.sv]
// ----------------------------------------------------------------------------
// dep_queue: work queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module dep_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  dep_pkg::q_entry_t push_data,
  input  logic              push_valid,
  output logic              push_ready,
  output dep_pkg::q_entry_t pop_data,
  output logic              pop_valid,
  input  logic              pop_ready
);
  import dep_pkg::*;

  q_entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = count_r != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/dep_back.sv]
// ----------------------------------------------------------------------------
// dep_back: expansion engine
// Owns the dictionary store, keeps the document count and running sum, drives
// the result channel and walks each segment one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module dep_back #(
  parameter int DICT_DEPTH = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dep_pkg::q_entry_t q_data,
  input  logic              q_valid,
  output logic              q_ready,
  dep_out_if.source         out_ch
);
  import dep_pkg::*;

  // The store depth is a power of two, so addresses wrap by truncation.
  localparam int DA_W = $clog2(DICT_DEPTH);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXPAND
  } state_t;

  typedef enum logic [1:0] {
    RD_BYTE,
    RD_ERROR,
    RD_START
  } rd_op_t;

  logic [BYTE_W-1:0] dict_mem [DICT_DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  base_r;
  logic [LEN_W-1:0]   seg_r;
  logic [LEN_W-1:0]   k_r, k_nxt;
  logic [DOC_W-1:0]   rem_r, rem_nxt;

  // Read stage: one beat in flight between the store and the output.
  logic               rd_valid_r, rd_valid_nxt;
  rd_op_t             rd_op_r, rd_op_nxt;
  logic               rd_last_r, rd_last_nxt;
  logic               rd_done_r, rd_done_nxt;

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic               out_last_r, out_done_r, out_err_r;

  logic               out_free, rd_move, issue_ok;
  logic               dict_wr, dict_rd;
  logic               seg_last, doc_end;
  logic [DA_W-1:0]    rd_addr;

  assign out_free = !out_valid_r || out_ch.ready;
  assign rd_move  = rd_valid_r && out_free;
  assign issue_ok = !rd_valid_r || out_free;

  assign rd_addr  = DA_W'({1'b0, base_r} + (ADDR_W+1)'(k_r));
  assign seg_last = (k_r + 1'b1) == seg_r;
  assign doc_end  = rem_r == DOC_W'(1);

  // Issue side: pops work, writes the store and starts byte reads.
  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    rem_nxt      = rem_r;
    q_ready      = 1'b0;
    dict_wr      = 1'b0;
    dict_rd      = 1'b0;
    rd_valid_nxt = rd_move ? 1'b0 : rd_valid_r;
    rd_op_nxt    = rd_op_r;
    rd_last_nxt  = rd_last_r;
    rd_done_nxt  = rd_done_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_data.op)
            Q_DICT_WR: begin
              q_ready = 1'b1;
              dict_wr = 1'b1;
            end
            Q_START: begin
              if (issue_ok) begin
                q_ready      = 1'b1;
                rem_nxt      = q_data.data;
                rd_valid_nxt = 1'b1;
                rd_op_nxt    = RD_START;
              end
            end
            Q_ERROR: begin
              if (issue_ok) begin
                q_ready      = 1'b1;
                rd_valid_nxt = 1'b1;
                rd_op_nxt    = RD_ERROR;
                rd_last_nxt  = 1'b1;
                rd_done_nxt  = 1'b0;
              end
            end
            default: begin
              q_ready = 1'b1;
              k_nxt   = '0;
              if (q_data.seg != '0 && rem_r != '0) begin
                state_nxt = ST_EXPAND;
              end
            end
          endcase
        end
      end
      ST_EXPAND: begin
        if (issue_ok) begin
          dict_rd      = 1'b1;
          rd_valid_nxt = 1'b1;
          rd_op_nxt    = RD_BYTE;
          rd_last_nxt  = seg_last || doc_end;
          rd_done_nxt  = doc_end;
          rem_nxt      = rem_r - 1'b1;
          k_nxt        = k_r + 1'b1;
          if (seg_last || doc_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dict_wr) begin
      dict_mem[DA_W'(q_data.addr)] <= q_data.data[BYTE_W-1:0];
    end
    if (dict_rd) begin
      rdata_r <= dict_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && state_r == ST_IDLE && q_data.op == Q_EXPAND) begin
      base_r <= q_data.addr;
      seg_r  <= q_data.seg;
    end
  end

  // Output side: the running sum is advanced as beats leave the read stage.
  always_comb begin
    sum_nxt       = sum_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (rd_move) begin
      case (rd_op_r)
        RD_START: begin
          sum_nxt = '0;
        end
        RD_ERROR: begin
          out_valid_nxt = 1'b1;
        end
        default: begin
          sum_nxt       = sum_r + SUM_W'(rdata_r);
          out_valid_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      rem_r       <= '0;
      rd_valid_r  <= 1'b0;
      rd_op_r     <= RD_BYTE;
      rd_last_r   <= 1'b0;
      rd_done_r   <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rem_r       <= rem_nxt;
      rd_valid_r  <= rd_valid_nxt;
      rd_op_r     <= rd_op_nxt;
      rd_last_r   <= rd_last_nxt;
      rd_done_r   <= rd_done_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (rd_move && rd_op_r != RD_START) begin
        out_byte_r <= (rd_op_r == RD_ERROR) ? '0 : rdata_r;
        out_sum_r  <= sum_nxt;
        out_last_r <= rd_last_r;
        out_done_r <= rd_done_r;
        out_err_r  <= rd_op_r == RD_ERROR;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.length_byte    = out_byte_r;
  assign out_ch.running_offset = out_sum_r;
  assign out_ch.last           = out_last_r;
  assign out_ch.doc_done       = out_done_r;
  assign out_ch.load_error     = out_err_r;

endmodule

[rtl/dictionary_expand_prefix_sum.sv]
// Path: front register, work queue, issue state, read stage, output register.
// Throughput: one result per cycle while a segment is walked and the output
// is not stalled (one dictionary read port); the queue is popped between walks.
// Reset: synchronous active-low rst_n clears queue, counters and running sum;
// code table and dictionary contents stay undefined until written.
// ----------------------------------------------------------------------------
// dictionary_expand_prefix_sum: dictionary expander with running offsets
// Front end with code table, work queue, and back end with dictionary store.
// Table and store depths are powers of two.
// ----------------------------------------------------------------------------
module dictionary_expand_prefix_sum #(
  parameter int CODE_TABLE_DEPTH = 4096,
  parameter int DICT_DEPTH       = 65536,
  parameter int MAX_SEGMENT      = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  dep_in_if.sink     in_ch,
  dep_out_if.source  out_ch
);
  import dep_pkg::*;

  q_entry_t push_data, pop_data;
  logic     push_valid, push_ready;
  logic     pop_valid, pop_ready;

  dep_front #(
    .CODE_TABLE_DEPTH (CODE_TABLE_DEPTH),
    .MAX_SEGMENT      (MAX_SEGMENT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_data  (push_data),
    .q_valid (push_valid),
    .q_ready (push_ready)
  );

  dep_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  dep_back #(
    .DICT_DEPTH (DICT_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (pop_data),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .out_ch  (out_ch)
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the dictionary expander
// A queue of load, start and code beats is built at time zero and driven with
// random gaps. A clocked predictor keeps its own code table, dictionary and
// running sum, and queues the bytes each accepted beat must produce. The
// monitor checks every result beat against the oldest queued byte.
// ----------------------------------------------------------------------------
module tb;
  import dep_pkg::*;

  localparam int TABLE_DEPTH = 4096;
  localparam int DICT_DEPTH  = 65536;
  localparam int MAX_SEG     = 64;
  localparam int RANDOM_ITEMS = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 32;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    kind_t             kind;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  entry_length;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] dict_byte;
    logic [DOC_W-1:0]  doc_length;
  } dep_item_t;

  typedef struct {
    logic [BYTE_W-1:0] length_byte;
    logic [SUM_W-1:0]  running_offset;
    logic              last;
    logic              doc_done;
    logic              load_error;
  } byte_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dep_in_if  in_ch();
  dep_out_if out_ch();

  dictionary_expand_prefix_sum #(
    .CODE_TABLE_DEPTH(TABLE_DEPTH),
    .DICT_DEPTH(DICT_DEPTH),
    .MAX_SEGMENT(MAX_SEG)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus and what the generator knows about which entries hold data.
  dep_item_t         send_queue[$];
  bit                dict_written[DICT_DEPTH];
  bit                code_usable[TABLE_DEPTH];
  logic [CODE_W-1:0] usable_codes[$];

  // Predictor state.
  logic [ENTRY_W-1:0] table_model[TABLE_DEPTH];
  logic [BYTE_W-1:0]  dict_model[DICT_DEPTH];
  logic [DOC_W-1:0]   doc_left = '0;
  logic [SUM_W-1:0]   offset_sum = '0;
  byte_result_t       expected_bytes[$];

  int mismatches = 0;
  int results_seen = 0;
  int in_gap = 0;
  int out_wait = 0;
  bit in_fast = 1'b0;
  bit out_fast = 1'b0;
  logic hold_active = 1'b0;
  logic hold_used = 1'b0;
  int hold_count = 0;

  function automatic dep_item_t rand_item(kind_t k);
    dep_item_t it;
    it.kind         = k;
    it.code         = CODE_W'($urandom);
    it.entry_length = LEN_W'($urandom);
    it.address      = ADDR_W'($urandom);
    it.dict_byte    = BYTE_W'($urandom);
    it.doc_length   = DOC_W'($urandom);
    return it;
  endfunction

  task automatic queue_dict(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] value);
    dep_item_t it;
    it = rand_item(KIND_LOAD_DICT);
    it.address = addr;
    it.dict_byte = value;
    dict_written[addr] = 1'b1;
    send_queue.push_back(it);
  endtask

  // An accepted load makes the code usable only if every byte of its segment
  // is already in the dictionary; a rejected load changes nothing.
  task automatic queue_entry(logic [CODE_W-1:0] code, int len, logic [ADDR_W-1:0] base);
    dep_item_t it;
    bit ok;
    it = rand_item(KIND_LOAD_CODE);
    it.code = code;
    it.entry_length = LEN_W'(len);
    it.address = base;
    if (len <= MAX_SEG) begin
      ok = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (!dict_written[ADDR_W'(base + ADDR_W'(k))]) ok = 1'b0;
      end
      code_usable[code] = ok;
      if (ok) usable_codes.push_back(code);
    end
    send_queue.push_back(it);
  endtask

  task automatic queue_start(logic [DOC_W-1:0] len);
    dep_item_t it;
    it = rand_item(KIND_START);
    it.doc_length = len;
    send_queue.push_back(it);
  endtask

  task automatic queue_code(logic [CODE_W-1:0] code);
    dep_item_t it;
    it = rand_item(KIND_CODE);
    it.code = code;
    send_queue.push_back(it);
  endtask

  task automatic expand_item(dep_item_t it);
    logic [ENTRY_W-1:0] entry;
    logic [LEN_W-1:0]   seg;
    logic [ADDR_W-1:0]  base;
    logic [BYTE_W-1:0]  b;
    byte_result_t       r;
    case (it.kind)
      KIND_LOAD_CODE: begin
        if (it.entry_length > MAX_SEG) begin
          r.length_byte = '0;
          r.running_offset = offset_sum;
          r.last = 1'b1;
          r.doc_done = 1'b0;
          r.load_error = 1'b1;
          expected_bytes.push_back(r);
        end else begin
          table_model[it.code] = {it.address, it.entry_length};
        end
      end
      KIND_LOAD_DICT: dict_model[it.address] = it.dict_byte;
      KIND_START: begin
        doc_left = it.doc_length;
        offset_sum = '0;
      end
      default: begin
        entry = table_model[it.code];
        seg = entry[LEN_W-1:0];
        base = entry[ENTRY_W-1:LEN_W];
        if (seg > MAX_SEG) seg = LEN_W'(MAX_SEG);
        for (int k = 0; k < seg && doc_left != 0; k++) begin
          b = dict_model[ADDR_W'(base + ADDR_W'(k))];
          offset_sum = offset_sum + SUM_W'(b);
          doc_left = doc_left - 1'b1;
          r.length_byte = b;
          r.running_offset = offset_sum;
          r.doc_done = (doc_left == 0);
          r.last = (k + 1 == seg) || r.doc_done;
          r.load_error = 1'b0;
          expected_bytes.push_back(r);
        end
      end
    endcase
  endtask

  // Each side alternates between stretches of back-to-back beats and
  // stretches of random waits.
  function automatic int draw_gap(inout bit fast);
    if ($urandom_range(0, 19) == 0) fast = !fast;
    return fast ? 0 : $urandom_range(0, 17);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expand_item(send_queue.pop_front());
        in_gap = draw_gap(in_fast);
      end else if (!in_ch.valid && in_gap > 0) begin
        in_gap--;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered beat until it is taken.
      end else if (in_gap == 0 && send_queue.size() > 0) begin
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= send_queue[0].kind;
        in_ch.code         <= send_queue[0].code;
        in_ch.entry_length <= send_queue[0].entry_length;
        in_ch.address      <= send_queue[0].address;
        in_ch.dict_byte    <= send_queue[0].dict_byte;
        in_ch.doc_length   <= send_queue[0].doc_length;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    byte_result_t want;
    bit bad;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: byte %0h offset %0h last %0b done %0b err %0b",
                     out_ch.length_byte, out_ch.running_offset, out_ch.last,
                     out_ch.doc_done, out_ch.load_error);
        end else begin
          want = expected_bytes.pop_front();
          bad = (out_ch.length_byte !== want.length_byte) ||
                (out_ch.running_offset !== want.running_offset) ||
                (out_ch.last !== want.last) ||
                (out_ch.doc_done !== want.doc_done) ||
                (out_ch.load_error !== want.load_error);
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $write("mismatch: want byte %0h offset %0h last %0b done %0b err %0b, ",
                     want.length_byte, want.running_offset, want.last, want.doc_done,
                     want.load_error);
              $display("got byte %0h offset %0h last %0b done %0b err %0b",
                       out_ch.length_byte, out_ch.running_offset, out_ch.last,
                       out_ch.doc_done, out_ch.load_error);
            end
          end
        end
        out_wait = draw_gap(out_fast);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_ch.ready <= (out_wait == 0) && !hold_active;
    end
  end

  // One long back-pressure episode, so the work queue fills and the input
  // side has to stall while the sender keeps offering beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_active <= 1'b0;
      hold_used <= 1'b0;
      hold_count <= 0;
    end else if (hold_active) begin
      if (hold_count == HOLD_CYCLES - 1) hold_active <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (!hold_used && results_seen >= 30) begin
      hold_active <= 1'b1;
      hold_used <= 1'b1;
      hold_count <= 0;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int start_size;
    int pick;
    int len;
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] last_base;
    logic [ADDR_W-1:0] a;

    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD_CODE;
    in_ch.code = '0;
    in_ch.entry_length = '0;
    in_ch.address = '0;
    in_ch.dict_byte = '0;
    in_ch.doc_length = '0;
    out_ch.ready = 1'b0;

    // Directed part. Code FFF walks a segment that wraps past the top of the
    // dictionary; code 123 is loaded at full length but never expanded.
    queue_dict(16'hFFFE, 8'hFF);
    queue_dict(16'hFFFF, 8'h80);
    queue_dict(16'h0000, 8'h00);
    queue_dict(16'h0001, 8'h7F);
    queue_entry(12'hFFF, 4, 16'hFFFE);
    queue_entry(12'h000, 0, 16'h0000);
    queue_entry(12'h123, MAX_SEG, 16'h8000);
    queue_entry(12'h555, MAX_SEG + 1, 16'h5555);
    queue_code(12'hFFF);
    queue_start(16'hFFFF);
    queue_code(12'hFFF);
    queue_code(12'h000);
    // Rejected while a sum is running; the old entry must survive.
    queue_entry(12'hFFF, 127, 16'h1234);
    queue_code(12'hFFF);
    // Second segment is cut short by the end of the document.
    queue_start(16'd6);
    queue_code(12'hFFF);
    queue_code(12'hFFF);
    queue_code(12'hFFF);
    queue_start(16'd0);
    queue_code(12'hFFF);

    start_size = send_queue.size();
    last_base = 16'h0100;
    queue_start(16'd40);
    while (send_queue.size() - start_size < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        code = CODE_W'($urandom);
        case ($urandom_range(0, 9))
          0: len = MAX_SEG;
          1: len = 0;
          default: len = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
          0: base = ADDR_W'($urandom);
          1: base = 16'hFFF0 + ADDR_W'($urandom_range(0, 15));
          default: base = last_base + ADDR_W'($urandom_range(0, 8));
        endcase
        last_base = base;
        for (int k = 0; k < len; k++) begin
          a = base + ADDR_W'(k);
          if (!dict_written[a]) queue_dict(a, BYTE_W'($urandom));
        end
        queue_entry(code, len, base);
      end else if (pick < 32) begin
        case ($urandom_range(0, 7))
          0: queue_start('0);
          1: queue_start(DOC_W'($urandom));
          default: queue_start(DOC_W'($urandom_range(1, 80)));
        endcase
      end else if (pick < 90) begin
        code = usable_codes[$urandom_range(0, usable_codes.size() - 1)];
        if (code_usable[code]) queue_code(code);
      end else if (pick < 95) begin
        queue_entry(CODE_W'($urandom), $urandom_range(MAX_SEG + 1, 127), ADDR_W'($urandom));
      end else begin
        queue_dict(ADDR_W'($urandom), BYTE_W'($urandom));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (send_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0d expected results never arrived", expected_bytes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dep_pkg.sv
rtl/dep_if.sv
rtl/dep_front.sv
rtl/dep_queue.sv
rtl/dep_back.sv
rtl/dictionary_expand_prefix_sum.sv
tb/tb.sv
